// File: rtl/vst_pkg.sv
`timescale 1ns / 1ps

package vst_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DefMaxJoints = 64;
  localparam int DefFracBits  = 16;

  // Element width and dot-product accumulator width (four 64-bit products).
  localparam int DataW = 32;
  localparam int AccW  = 66;

  // Blend weights are Q1.15.
  localparam int WeightFracBits = 15;

  // Input item kinds.
  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeVertex = 1'b1;

  // Configuration register indexes.
  localparam logic CfgAnimationEnable = 1'b0;
  localparam logic CfgJointCount      = 1'b1;

  // Matrix store selects in load_address[12:10].
  localparam logic [2:0] TabJoint       = 3'd0;
  localparam logic [2:0] TabJointNormal = 3'd1;
  localparam logic [2:0] TabModel       = 3'd2;
  localparam logic [2:0] TabView        = 3'd3;
  localparam logic [2:0] TabProjection  = 3'd4;
  localparam logic [2:0] TabModelNormal = 3'd5;

  // Work phases of one vertex, in execution order.
  typedef enum logic [2:0] {
    PH_BLEND_M = 3'd0,
    PH_BLEND_N = 3'd1,
    PH_POS     = 3'd2,
    PH_MODEL   = 3'd3,
    PH_VIEW    = 3'd4,
    PH_PROJ    = 3'd5,
    PH_NRM     = 3'd6,
    PH_NMAT    = 3'd7
  } phase_t;

  // One multiply-accumulate term issued by the controller.
  typedef struct packed {
    logic       valid;
    phase_t     phase;
    logic [3:0] row;
    logic [1:0] col;
    logic       first;
    logic       last;
  } issue_t;

  typedef struct packed {
    issue_t issue;
    logic   publish;
  } dp_cmd_t;

  typedef struct packed {
    logic blend_on;
    logic out_busy;
  } dp_status_t;

  // Index of the last output row computed in a phase.
  function automatic logic [3:0] last_row(phase_t p);
    logic [3:0] r;
    case (p)
      PH_BLEND_M, PH_BLEND_N: r = 4'd15;
      PH_VIEW, PH_PROJ:       r = 4'd3;
      default:                r = 4'd2;
    endcase
    return r;
  endfunction

  // Index of the last term in one dot product of a phase.
  function automatic logic [1:0] last_col(phase_t p);
    return (p == PH_NMAT) ? 2'd2 : 2'd3;
  endfunction

  function automatic logic is_blend(phase_t p);
    return (p == PH_BLEND_M) || (p == PH_BLEND_N);
  endfunction

  // Saturate an accumulator-wide value to 32 signed bits.
  function automatic logic [DataW-1:0] sat32(logic [AccW-1:0] x);
    logic [DataW-1:0] r;
    if (!x[AccW-1] && (|x[AccW-2:DataW-1])) begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end else if (x[AccW-1] && !(&x[AccW-2:DataW-1])) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

  // Remainder of a 6-bit joint index by the joint capacity, by restoring steps.
  function automatic logic [7:0] wrap_joint(logic [5:0] idx, logic [8:0] maxj);
    logic [8:0] rem;
    rem = '0;
    for (int i = 5; i >= 0; i--) begin
      rem = {rem[7:0], idx[i]};
      if (rem >= maxj) begin
        rem = rem - maxj;
      end
    end
    return rem[7:0];
  endfunction

endpackage

// File: rtl/vst_ctrl.sv
`timescale 1ns / 1ps

module vst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                mode,
  output logic                in_ready,
  input  vst_pkg::dp_status_t status,
  output vst_pkg::dp_cmd_t    cmd
);
  import vst_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [3:0] row, row_next;
  logic [1:0] col, col_next;
  logic       drain, drain_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Command outputs follow the sequencer registers.
  always_comb begin
    cmd.issue.valid = (state == ST_ISSUE);
    cmd.issue.phase = phase;
    cmd.issue.row   = row;
    cmd.issue.col   = col;
    cmd.issue.first = (col == 2'd0);
    cmd.issue.last  = (col == last_col(phase));
    cmd.publish     = (state == ST_FINISH) && !status.out_busy;
  end

  // Sequencer: walk the terms of each phase, then let the pipeline drain.
  always_comb begin
    state_next = state;
    phase_next = phase;
    row_next   = row;
    col_next   = col;
    drain_next = drain;
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode == ModeVertex)) begin
          state_next = ST_ISSUE;
          phase_next = status.blend_on ? PH_BLEND_M : PH_POS;
          row_next   = 4'd0;
          col_next   = 2'd0;
        end
      end
      ST_ISSUE: begin
        if (col == last_col(phase)) begin
          col_next = 2'd0;
          if (row == last_row(phase)) begin
            state_next = ST_DRAIN;
            drain_next = 1'b0;
          end else begin
            row_next = row + 4'd1;
          end
        end else begin
          col_next = col + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (drain) begin
          row_next = 4'd0;
          if (phase == PH_NMAT) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_ISSUE;
            phase_next = phase_t'(3'(phase + 3'd1));
          end
        end else begin
          drain_next = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_POS;
      row   <= 4'd0;
      col   <= 2'd0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      row   <= row_next;
      col   <= col_next;
      drain <= drain_next;
    end
  end

  // A result waiting on a stalled output register holds the sequencer.
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && status.out_busy) |=> (state == ST_FINISH))
    else $error("finish left while output register busy");

  // A vertex transaction starts at the first term.
  a_vertex_start: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == ModeVertex) |=> (state == ST_ISSUE && row == 4'd0 && col == 2'd0))
    else $error("vertex did not start issuing at first term");

  // The last term of the last row ends the phase.
  a_phase_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue.valid && cmd.issue.last && row == last_row(phase)) |=> (state == ST_DRAIN))
    else $error("phase did not end after its last term");

endmodule

// File: rtl/vst_datapath.sv
`timescale 1ns / 1ps

module vst_datapath #(
  parameter int MAX_JOINTS = vst_pkg::DefMaxJoints,
  parameter int FRAC_BITS  = vst_pkg::DefFracBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                mode,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  nrm_x,
  input  logic signed [31:0]  nrm_y,
  input  logic signed [31:0]  nrm_z,
  input  logic [23:0]         joint_indices,
  input  logic [63:0]         blend_weights,
  input  logic [12:0]         load_address,
  input  logic signed [31:0]  load_value,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data,
  input  vst_pkg::dp_cmd_t    cmd,
  output vst_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  world_x,
  output logic signed [31:0]  world_y,
  output logic signed [31:0]  world_z,
  output logic signed [31:0]  normal_x,
  output logic signed [31:0]  normal_y,
  output logic signed [31:0]  normal_z,
  output logic signed [31:0]  clip_x,
  output logic signed [31:0]  clip_y,
  output logic signed [31:0]  clip_z,
  output logic signed [31:0]  clip_w
);
  import vst_pkg::*;

  localparam int JW     = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int JAW    = JW + 4;
  localparam int JDepth = MAX_JOINTS * 16;
  localparam logic [8:0] MaxJ = 9'(MAX_JOINTS);
  localparam logic [DataW-1:0] One = DataW'(1) << FRAC_BITS;

  // Configuration registers.
  logic       animation_enable;
  logic [6:0] joint_count;

  // Vertex operands captured at acceptance.
  logic [DataW-1:0] pos_q [3];
  logic [DataW-1:0] nrm_q [3];
  logic [JW-1:0]    idx_q [4];
  logic [15:0]      wt_q  [4];

  // Matrix stores.
  logic [DataW-1:0] joint_mem  [JDepth];
  logic [DataW-1:0] jnorm_mem  [JDepth];
  logic [DataW-1:0] fixed_mem  [64];
  logic [DataW-1:0] joint_q, jnorm_q, fixed_q, bsel_q;
  logic [DataW-1:0] bm [16];
  logic [DataW-1:0] bn [16];

  // Intermediate vectors.
  logic [DataW-1:0] t_v     [3];
  logic [DataW-1:0] world_v [3];
  logic [DataW-1:0] vw_v    [4];
  logic [DataW-1:0] clip_v  [4];
  logic [DataW-1:0] n1_v    [3];
  logic [DataW-1:0] n2_v    [3];

  // Pipeline.
  issue_t                  s1, s2;
  logic signed [DataW-1:0] op_a, op_b;
  logic signed [63:0]      prod;
  logic signed [AccW-1:0]  acc, sum;
  logic [DataW-1:0]        res;

  // Load decode.
  logic [2:0]     tab;
  logic [7:0]     jnt8;
  logic           jnt_ok;
  logic [JAW-1:0] jw_addr, jr_addr;
  logic [5:0]     fw_addr, fr_addr;
  logic [1:0]     fr_base, fw_base;
  logic           load_acc;
  logic [3:0]     b_elem;

  assign load_acc = accept && (mode == ModeLoad);
  assign tab      = load_address[12:10];
  assign jnt8     = {2'b00, load_address[9:4]};
  assign jnt_ok   = ({1'b0, jnt8} < MaxJ);
  assign jw_addr  = {jnt8[JW-1:0], load_address[3:0]};
  assign fw_base  = 2'(tab - TabModel);
  assign fw_addr  = {fw_base, load_address[3:0]};

  assign status.blend_on = animation_enable && (joint_count != 7'd0);
  assign status.out_busy = out_valid && !out_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      animation_enable <= 1'b0;
      joint_count      <= 7'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgAnimationEnable: animation_enable <= cfg_data[0];
        CfgJointCount:      joint_count      <= cfg_data;
      endcase
    end
  end

  // Capture the vertex operands.
  always_ff @(posedge clk) begin
    if (accept && (mode == ModeVertex)) begin
      pos_q[0] <= pos_x;
      pos_q[1] <= pos_y;
      pos_q[2] <= pos_z;
      nrm_q[0] <= nrm_x;
      nrm_q[1] <= nrm_y;
      nrm_q[2] <= nrm_z;
      for (int k = 0; k < 4; k++) begin
        idx_q[k] <= JW'(wrap_joint(joint_indices[6*k +: 6], MaxJ));
        wt_q[k]  <= blend_weights[16*k+15] ? 16'd0 : blend_weights[16*k +: 16];
      end
    end
  end

  // Read addresses for the issued term.
  assign jr_addr = {idx_q[cmd.issue.col], cmd.issue.row};
  assign b_elem  = {cmd.issue.col, cmd.issue.row[1:0]};

  always_comb begin
    case (cmd.issue.phase)
      PH_VIEW: fr_base = 2'd1;
      PH_PROJ: fr_base = 2'd2;
      PH_NMAT: fr_base = 2'd3;
      default: fr_base = 2'd0;
    endcase
  end
  assign fr_addr = {fr_base, cmd.issue.col, cmd.issue.row[1:0]};

  // Joint tables: one write port for loads, one registered read.
  always_ff @(posedge clk) begin
    if (load_acc && (tab == TabJoint) && jnt_ok) begin
      joint_mem[jw_addr] <= load_value;
    end
    joint_q <= joint_mem[jr_addr];
  end

  always_ff @(posedge clk) begin
    if (load_acc && (tab == TabJointNormal) && jnt_ok) begin
      jnorm_mem[jw_addr] <= load_value;
    end
    jnorm_q <= jnorm_mem[jr_addr];
  end

  // Model, view, projection and model normal matrices.
  always_ff @(posedge clk) begin
    if (load_acc && (tab >= TabModel) && (tab <= TabModelNormal)) begin
      fixed_mem[fw_addr] <= load_value;
    end
    fixed_q <= fixed_mem[fr_addr];
  end

  // Blended matrix read, aligned with the memory reads.
  always_ff @(posedge clk) begin
    bsel_q <= (cmd.issue.phase == PH_NRM) ? bn[b_elem] : bm[b_elem];
  end

  // Operand selection for the multiplier.
  always_comb begin
    case (s1.phase)
      PH_BLEND_M:     op_a = joint_q;
      PH_BLEND_N:     op_a = jnorm_q;
      PH_POS, PH_NRM: op_a = bsel_q;
      default:        op_a = fixed_q;
    endcase
    case (s1.phase)
      PH_BLEND_M, PH_BLEND_N: op_b = {16'd0, wt_q[s1.col]};
      PH_POS:   op_b = (s1.col == 2'd3) ? One : pos_q[s1.col];
      PH_MODEL: op_b = (s1.col == 2'd3) ? One : t_v[s1.col];
      PH_VIEW:  op_b = (s1.col == 2'd3) ? One : world_v[s1.col];
      PH_PROJ:  op_b = vw_v[s1.col];
      PH_NRM:   op_b = (s1.col == 2'd3) ? One : nrm_q[s1.col];
      default:  op_b = n1_v[s1.col];
    endcase
  end

  // Pipeline control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= cmd.issue;
      s2 <= s1;
    end
  end

  // Product register.
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  // Accumulate, then floor-shift and saturate the finished dot product.
  assign sum = s2.first ? {{(AccW-64){prod[63]}}, prod}
                        : acc + {{(AccW-64){prod[63]}}, prod};
  assign res = is_blend(s2.phase) ? sat32(sum >>> WeightFracBits)
                                  : sat32(sum >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (s2.valid) begin
      acc <= sum;
    end
  end

  // Stored blends, identity after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < 16; e++) begin
        bm[e] <= ((e % 5) == 0) ? One : '0;
        bn[e] <= ((e % 5) == 0) ? One : '0;
      end
    end else if (s2.valid && s2.last) begin
      if (s2.phase == PH_BLEND_M) begin
        bm[s2.row] <= res;
      end
      if (s2.phase == PH_BLEND_N) begin
        bn[s2.row] <= res;
      end
    end
  end

  // Intermediate vector writes.
  always_ff @(posedge clk) begin
    if (s2.valid && s2.last) begin
      case (s2.phase)
        PH_POS:   t_v[s2.row[1:0]]     <= res;
        PH_MODEL: world_v[s2.row[1:0]] <= res;
        PH_VIEW:  vw_v[s2.row[1:0]]    <= res;
        PH_PROJ:  clip_v[s2.row[1:0]]  <= res;
        PH_NRM:   n1_v[s2.row[1:0]]    <= res;
        PH_NMAT:  n2_v[s2.row[1:0]]    <= res;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      world_x  <= world_v[0];
      world_y  <= world_v[1];
      world_z  <= world_v[2];
      normal_x <= n2_v[0];
      normal_y <= n2_v[1];
      normal_z <= n2_v[2];
      clip_x   <= clip_v[0];
      clip_y   <= clip_v[1];
      clip_z   <= clip_v[2];
      clip_w   <= clip_v[3];
    end
  end

endmodule

// File: rtl/vertex_skin_transform.sv
`timescale 1ns / 1ps

// Linear blend skinning vertex transform in Q16.16 fixed point. A load
// transaction (mode 0) writes one matrix element and completes with no
// result. A vertex transaction (mode 1) gives one result with world
// position, transformed normal and clip position. All work runs through one
// shared 32x32 multiply-accumulate pipeline fed by matrix stores with one
// write and one registered read port, one term per cycle, with a drain
// between dependent matrix-vector steps. Animation enabled with a nonzero
// joint_count adds 128 blend terms per vertex. The next transaction is
// accepted as soon as the result is in the output register.
// The joint stores hold MAX_JOINTS*16 elements each and need no clearing.

module vertex_skin_transform #(
  parameter int MAX_JOINTS = vst_pkg::DefMaxJoints,
  parameter int FRAC_BITS  = vst_pkg::DefFracBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] nrm_x,
  input  logic signed [31:0] nrm_y,
  input  logic signed [31:0] nrm_z,
  input  logic [23:0]        joint_indices,
  input  logic [63:0]        blend_weights,
  input  logic [12:0]        load_address,
  input  logic signed [31:0] load_value,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] world_x,
  output logic signed [31:0] world_y,
  output logic signed [31:0] world_z,
  output logic signed [31:0] normal_x,
  output logic signed [31:0] normal_y,
  output logic signed [31:0] normal_z,
  output logic signed [31:0] clip_x,
  output logic signed [31:0] clip_y,
  output logic signed [31:0] clip_z,
  output logic signed [31:0] clip_w
);
  import vst_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  vst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  vst_datapath #(
    .MAX_JOINTS (MAX_JOINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_valid && in_ready),
    .mode          (mode),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .nrm_x         (nrm_x),
    .nrm_y         (nrm_y),
    .nrm_z         (nrm_z),
    .joint_indices (joint_indices),
    .blend_weights (blend_weights),
    .load_address  (load_address),
    .load_value    (load_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .world_x       (world_x),
    .world_y       (world_y),
    .world_z       (world_z),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .clip_x        (clip_x),
    .clip_y        (clip_y),
    .clip_z        (clip_z),
    .clip_w        (clip_w)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import vst_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 300;
  localparam int One = 32'sh0001_0000;

  typedef struct {
    logic mode;
    int px, py, pz, nx, ny, nz;
    logic [23:0] jidx;
    logic [63:0] wts;
    logic [12:0] addr;
    int val;
  } vtx_item_t;

  typedef struct {
    int f[10];
  } vtx_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CfgAnimationEnable;
  logic [6:0] cfg_data = '0;
  logic signed [31:0] world_x, world_y, world_z, normal_x, normal_y, normal_z;
  logic signed [31:0] clip_x, clip_y, clip_z, clip_w;

  vtx_item_t cur = '{mode: ModeLoad, default: 0};
  vtx_item_t pending_items[$];
  vtx_result_t expected_results[$];

  // Shadow of the block's stores and registers.
  int sh_joint[1024];
  int sh_jnorm[1024];
  int sh_fixed[64];
  int sh_bmodel[16];
  int sh_bnormal[16];
  logic sh_anim = 1'b0;
  logic [6:0] sh_jcount = '0;

  int mismatches = 0;
  int cycles = 0;
  logic took = 1'b0;
  logic hold = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int run_left = 0;

  vertex_skin_transform uut (
    .clk, .rst, .in_valid, .in_ready, .mode(cur.mode),
    .pos_x(cur.px), .pos_y(cur.py), .pos_z(cur.pz),
    .nrm_x(cur.nx), .nrm_y(cur.ny), .nrm_z(cur.nz),
    .joint_indices(cur.jidx), .blend_weights(cur.wts),
    .load_address(cur.addr), .load_value(cur.val),
    .cfg_we, .cfg_index, .cfg_data, .out_valid, .out_ready,
    .world_x, .world_y, .world_z, .normal_x, .normal_y, .normal_z,
    .clip_x, .clip_y, .clip_z, .clip_w
  );

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int sat_to32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return int'(x);
  endfunction

  // Exact floor of the dot product over 2^16, then saturated.
  function automatic int fx_dot(int a[4], int b[4], int n);
    longint hi, lo, p;
    hi = 0;
    lo = 0;
    for (int i = 0; i < n; i++) begin
      p = longint'(a[i]) * longint'(b[i]);
      hi += p >>> 16;
      lo += p & 64'hFFFF;
    end
    return sat_to32(hi + (lo >>> 16));
  endfunction

  // Column-major matrix times vector, n columns used.
  function automatic void fx_mat_vec(int m[16], int v[4], int n, output int o[4]);
    int row[4];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) row[c] = m[c*4 + r];
      o[r] = fx_dot(row, v, n);
    end
  endfunction

  function automatic void fixed_mat(int sel, output int m[16]);
    for (int e = 0; e < 16; e++) m[e] = sh_fixed[sel*16 + e];
  endfunction

  // Update the shadow state for one transaction and return its result, if any.
  function automatic bit skin_predict(vtx_item_t it, output vtx_result_t res);
    int idx[4];
    longint wt[4];
    longint acc_m, acc_n;
    logic [15:0] ws;
    int v[4], t[4], w1[4], vw[4], clp[4], n1[4], n2[4], m[16];
    int tab, off;
    if (it.mode == ModeLoad) begin
      tab = it.addr[12:10];
      off = it.addr[9:0];
      if (tab == TabJoint) sh_joint[off] = it.val;
      else if (tab == TabJointNormal) sh_jnorm[off] = it.val;
      else if (tab <= TabModelNormal) sh_fixed[(tab - TabModel)*16 + (off & 15)] = it.val;
      return 0;
    end
    if (sh_anim && sh_jcount != 0) begin
      for (int k = 0; k < 4; k++) begin
        ws = it.wts[16*k +: 16];
        idx[k] = it.jidx[6*k +: 6] % 64;
        wt[k] = ws[15] ? 0 : longint'(ws);
      end
      for (int e = 0; e < 16; e++) begin
        acc_m = 0;
        acc_n = 0;
        for (int k = 0; k < 4; k++) begin
          if (wt[k] > 0) begin
            acc_m += wt[k] * longint'(sh_joint[idx[k]*16 + e]);
            acc_n += wt[k] * longint'(sh_jnorm[idx[k]*16 + e]);
          end
        end
        sh_bmodel[e] = sat_to32(acc_m >>> 15);
        sh_bnormal[e] = sat_to32(acc_n >>> 15);
      end
    end
    v = '{it.px, it.py, it.pz, One};
    fx_mat_vec(sh_bmodel, v, 4, t);
    t[3] = One;
    fixed_mat(0, m);
    fx_mat_vec(m, t, 4, w1);
    w1[3] = One;
    fixed_mat(1, m);
    fx_mat_vec(m, w1, 4, vw);
    fixed_mat(2, m);
    fx_mat_vec(m, vw, 4, clp);
    v = '{it.nx, it.ny, it.nz, One};
    fx_mat_vec(sh_bnormal, v, 4, n1);
    n1[3] = 0;
    fixed_mat(3, m);
    fx_mat_vec(m, n1, 3, n2);
    res.f = '{w1[0], w1[1], w1[2], n2[0], n2[1], n2[2], clp[0], clp[1], clp[2], clp[3]};
    return 1;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Record accepted input transactions and predict their results.
  always @(posedge clk) begin
    vtx_result_t r;
    if (!rst && in_valid && in_ready) begin
      if (skin_predict(cur, r)) expected_results.push_back(r);
      took <= 1'b1;
    end else begin
      took <= 1'b0;
    end
  end

  // Sender: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (!rst && !(in_valid && !took)) begin
      if (gap_left > 0 || hold || pending_items.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        cur <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: alternating ready runs and stalls of random lengths.
  always @(negedge clk) begin
    if (run_left > 0) begin
      out_ready <= 1'b1;
      run_left <= run_left - 1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      run_left <= $urandom_range(1, 300);
      stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
    end
  end

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    int act[10];
    vtx_result_t e;
    string nm[10];
    nm = '{"world_x", "world_y", "world_z", "normal_x", "normal_y", "normal_z",
           "clip_x", "clip_y", "clip_z", "clip_w"};
    act = '{world_x, world_y, world_z, normal_x, normal_y, normal_z,
            clip_x, clip_y, clip_z, clip_w};
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10) $display("Unexpected result transaction at cycle %0d", cycles);
        mismatches = mismatches + 1;
      end else begin
        e = expected_results.pop_front();
        for (int i = 0; i < 10; i++) begin
          if (e.f[i] != act[i]) begin
            if (mismatches < 10)
              $display("Mismatch %s: expected %h got %h", nm[i], e.f[i], act[i]);
            mismatches = mismatches + 1;
          end
        end
      end
    end
  end

  // Matrix element value: mostly moderate, sometimes anywhere in range.
  function automatic int rand_elem();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? One : -One;
      2: return 0;
      default: return int'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  // Only joints 0..3 and 60..63 are ever loaded and referenced.
  function automatic logic [5:0] rand_joint();
    logic [5:0] j;
    j = $urandom_range(0, 3);
    return $urandom_range(0, 1) ? j : 6'd60 + j;
  endfunction

  function automatic vtx_item_t load_item(logic [12:0] a, int v);
    vtx_item_t it;
    it = '{mode: ModeLoad, default: 0};
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.nx = $urandom; it.ny = $urandom; it.nz = $urandom;
    it.jidx = $urandom;
    it.wts = {$urandom, $urandom};
    it.addr = a;
    it.val = v;
    return it;
  endfunction

  function automatic vtx_item_t vertex_item(int px, int py, int pz, int nx, int ny, int nz,
                                            logic [23:0] ji, logic [63:0] w);
    vtx_item_t it;
    it = '{mode: ModeVertex, default: 0};
    it.px = px; it.py = py; it.pz = pz;
    it.nx = nx; it.ny = ny; it.nz = nz;
    it.jidx = ji;
    it.wts = w;
    it.addr = $urandom;
    it.val = $urandom;
    return it;
  endfunction

  function automatic vtx_item_t rand_vertex();
    logic [23:0] ji;
    logic [63:0] w;
    logic [15:0] lane;
    for (int k = 0; k < 4; k++) begin
      ji[6*k +: 6] = rand_joint();
      case ($urandom_range(0, 5))
        0: lane = 16'h8000 | 16'($urandom);
        1: lane = 16'h0000;
        2: lane = 16'h7FFF;
        default: lane = $urandom_range(0, 16'h7FFF);
      endcase
      w[16*k +: 16] = lane;
    end
    return vertex_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), ji, w);
  endfunction

  function automatic vtx_item_t rand_load();
    logic [2:0] tab;
    logic [9:0] off;
    tab = $urandom_range(0, 7);
    off = $urandom;
    if (tab == TabJoint || tab == TabJointNormal) off = {rand_joint(), off[3:0]};
    return load_item({tab, off}, rand_elem());
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_cfg(logic anim, logic [6:0] jc);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CfgAnimationEnable;
    cfg_data <= {6'd0, anim};
    @(negedge clk);
    cfg_index <= CfgJointCount;
    cfg_data <= jc;
    @(negedge clk);
    cfg_we <= 1'b0;
    sh_anim = anim;
    sh_jcount = jc;
  endtask

  // Stimulus sequence.
  initial begin
    logic [6:0] jc_set[6];
    logic an_set[6];
    logic [5:0] j;
    for (int i = 0; i < 16; i++) begin
      sh_bmodel[i] = (i % 5 == 0) ? One : 0;
      sh_bnormal[i] = (i % 5 == 0) ? One : 0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_cfg(1'b0, 7'd0);

    // Fill every fixed matrix and the joints that vertices will use.
    for (int t = TabModel; t <= TabModelNormal; t++)
      for (int e = 0; e < 16; e++)
        pending_items.push_back(load_item({3'(t), 6'($urandom), 4'(e)},
                                          (e % 5 == 0) ? One : rand_elem()));
    for (int k = 0; k < 8; k++) begin
      j = (k < 4) ? 6'(k) : 6'(56 + k);
      for (int e = 0; e < 16; e++) begin
        pending_items.push_back(load_item({TabJoint, j, 4'(e)}, rand_elem()));
        pending_items.push_back(load_item({TabJointNormal, j, 4'(e)}, rand_elem()));
      end
    end

    // Directed vertices with identity blends: coordinate extremes.
    pending_items.push_back(vertex_item(0, 0, 0, 0, 0, 0, '0, '0));
    pending_items.push_back(vertex_item(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                        32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                        '1, '1));
    pending_items.push_back(vertex_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                        '0, '0));
    pending_items.push_back(vertex_item(-1, 1, -One, One, -1, 0, '0, '0));
    // Loads to the unused tables are ignored.
    pending_items.push_back(load_item({3'd6, 10'h3FF}, 32'sh7fff_ffff));
    pending_items.push_back(load_item({3'd7, 10'h000}, 32'sh8000_0000));
    pending_items.push_back(vertex_item(One, One, One, One, One, One, '0, '0));
    wait_idle();

    // Blending on: weight extremes, negative weights and an index past joint_count.
    write_cfg(1'b1, 7'd1);
    pending_items.push_back(vertex_item(One, -One, One, One, One, -One,
                                        {6'd63, 6'd60, 6'd3, 6'd0},
                                        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}));
    pending_items.push_back(vertex_item(One, One, One, One, One, One,
                                        {6'd62, 6'd61, 6'd2, 6'd1},
                                        {16'h8000, 16'hFFFF, 16'h0000, 16'h4000}));
    pending_items.push_back(vertex_item(One, One, One, One, One, One, '0, '0));
    pending_items.push_back(vertex_item(32'sh7fff_ffff, 32'sh8000_0000, 0,
                                        32'sh8000_0000, 32'sh7fff_ffff, 0,
                                        {6'd0, 6'd63, 6'd0, 6'd63}, {4{16'h7FFF}}));
    wait_idle();

    // Random phases across register settings, extremes among them.
    an_set = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    jc_set = '{7'd0, 7'd64, 7'd1, 7'd127, 7'd64, 7'd0};
    for (int p = 0; p < 6; p++) begin
      write_cfg(an_set[p], jc_set[p]);
      for (int n = 0; n < 70; n++) begin
        if ($urandom_range(0, 9) < 3) pending_items.push_back(rand_load());
        else pending_items.push_back(rand_vertex());
        // Hold off once mid-phase until every result is back.
        if (p == 1 && n == 60) begin
          while (pending_items.size() != 0 || in_valid) @(posedge clk);
          hold = 1'b1;
          while (expected_results.size() != 0) @(posedge clk);
          hold = 1'b0;
        end
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/vst_pkg.sv
rtl/vst_ctrl.sv
rtl/vst_datapath.sv
rtl/vertex_skin_transform.sv
tb/tb.sv
